/* hdl/pal_pkg.sv */
// Shared types, constants and codes for the positional array list.
`default_nettype none

package pal_pkg;

    // Store geometry
    localparam int CAPACITY = 64;
    localparam int ADDR_W   = $clog2(CAPACITY);
    localparam int CNT_W    = $clog2(CAPACITY + 1);

    // Field widths
    localparam int OP_W     = 3;
    localparam int POS_W    = 7;
    localparam int DATA_W   = 32;
    localparam int STATUS_W = 2;
    localparam int COUNT_W  = 7;
    localparam int CMP_W    = (CNT_W > POS_W) ? CNT_W : POS_W;

    // Operation codes
    localparam logic [OP_W-1:0] OP_INSERT  = 3'd0;
    localparam logic [OP_W-1:0] OP_REMOVE  = 3'd1;
    localparam logic [OP_W-1:0] OP_REPLACE = 3'd2;
    localparam logic [OP_W-1:0] OP_GET     = 3'd3;
    localparam logic [OP_W-1:0] OP_FIND    = 3'd4;
    localparam logic [OP_W-1:0] OP_CLEAR   = 3'd5;

    // Result status codes
    localparam logic [STATUS_W-1:0] ST_OK   = 2'd0;
    localparam logic [STATUS_W-1:0] ST_BAD  = 2'd1;
    localparam logic [STATUS_W-1:0] ST_FULL = 2'd2;

    typedef struct packed {
        logic [OP_W-1:0]          op;
        logic [POS_W-1:0]         pos;
        logic signed [DATA_W-1:0] value;
    } pal_in_t;

    typedef struct packed {
        logic [STATUS_W-1:0]      status;
        logic signed [DATA_W-1:0] read_value;
        logic                     found;
        logic [COUNT_W-1:0]       count;
    } pal_out_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_DECODE,
        S_INS_LOOP,
        S_INS_WR,
        S_REM_LOOP,
        S_REM_WR,
        S_GET_CAP,
        S_FIND_LOOP,
        S_FIND_CHK,
        S_RESP
    } state_t;

    typedef enum logic [2:0] {
        IDX_HOLD,
        IDX_COUNT,
        IDX_POS1,
        IDX_ZERO,
        IDX_INC,
        IDX_DEC
    } idx_op_t;

    typedef enum logic [1:0] {
        CNT_HOLD,
        CNT_INC,
        CNT_DEC,
        CNT_CLR
    } cnt_op_t;

    typedef enum logic [1:0] {
        RA_IDX_M1,
        RA_IDX,
        RA_POS
    } rd_sel_t;

    typedef enum logic [1:0] {
        WA_IDX,
        WA_IDX_M1,
        WA_POS
    } wr_sel_t;

    typedef struct packed {
        logic                take;
        logic                status_set;
        logic [STATUS_W-1:0] status_code;
        idx_op_t             idx_op;
        logic                rd_en;
        rd_sel_t             rd_sel;
        logic                wr_en;
        wr_sel_t             wr_sel;
        cnt_op_t             cnt_op;
        logic                read_cap;
        logic                found_set;
        logic                out_load;
    } pal_cmd_t;

    typedef struct packed {
        logic [OP_W-1:0] op;
        logic            pos_le_cnt;
        logic            pos_lt_cnt;
        logic            full;
        logic            idx_gt_pos;
        logic            idx_lt_cnt;
        logic            match;
        logic            out_free;
    } pal_sts_t;

endpackage

`default_nettype wire

/* hdl/positional_array_list.sv */
// Each item is decoded, then insert and remove shift the entries between pos and count, get
// reads the entry at pos, and find scans from the head until a match or the end of the list.
// Each entry is read, then written or compared, on the store's single read/write pair.
// A new input transfer is taken the cycle after the result enters the output register,
// which holds it until the result transfer while the next item is taken.
// Synchronous active-low reset empties the list; stored entries are not cleared.
`default_nettype none

module positional_array_list
    import pal_pkg::*;
(
    input  wire logic    aclk,
    input  wire logic    aresetn,
    input  wire logic    s_valid,
    output logic         s_ready,
    input  wire pal_in_t s_data,
    output logic         m_valid,
    input  wire logic    m_ready,
    output pal_out_t     m_data
);

    pal_cmd_t cmd;
    pal_sts_t sts;

    pal_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .sts     (sts),
        .cmd     (cmd)
    );

    pal_dp u_dp (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data),
        .cmd     (cmd),
        .sts     (sts)
    );

endmodule

`default_nettype wire

/* hdl/pal_ram.sv */
// Generic simple dual-port RAM with registered read.
`default_nettype none

module pal_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  wire logic                     aclk,
    input  wire logic                     wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]         wr_data,
    input  wire logic                     rd_en,
    input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic      [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    // Write port
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem_reg[wr_addr] <= wr_data;
        end
    end

    // Registered read port
    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_data_reg <= mem_reg[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

`default_nettype wire

/* hdl/pal_ctrl.sv */
// Controller state machine that sequences each list operation.
`default_nettype none

module pal_ctrl
    import pal_pkg::*;
(
    input  wire logic     aclk,
    input  wire logic     aresetn,
    input  wire logic     s_valid,
    output logic          s_ready,
    input  wire pal_sts_t sts,
    output pal_cmd_t      cmd
);

    state_t state_reg;
    state_t state_next;

    // Hold state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    // Next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE: begin
                if (s_valid) begin
                    state_next = S_DECODE;
                end
            end
            S_DECODE: begin
                case (sts.op)
                    OP_INSERT: begin
                        if (sts.pos_le_cnt && !sts.full) begin
                            state_next = S_INS_LOOP;
                        end else begin
                            state_next = S_RESP;
                        end
                    end
                    OP_REMOVE: begin
                        if (sts.pos_lt_cnt) begin
                            state_next = S_REM_LOOP;
                        end else begin
                            state_next = S_RESP;
                        end
                    end
                    OP_GET: begin
                        if (sts.pos_lt_cnt) begin
                            state_next = S_GET_CAP;
                        end else begin
                            state_next = S_RESP;
                        end
                    end
                    OP_FIND:  state_next = S_FIND_LOOP;
                    default:  state_next = S_RESP;
                endcase
            end
            S_INS_LOOP: begin
                if (sts.idx_gt_pos) begin
                    state_next = S_INS_WR;
                end else begin
                    state_next = S_RESP;
                end
            end
            S_INS_WR:   state_next = S_INS_LOOP;
            S_REM_LOOP: begin
                if (sts.idx_lt_cnt) begin
                    state_next = S_REM_WR;
                end else begin
                    state_next = S_RESP;
                end
            end
            S_REM_WR:   state_next = S_REM_LOOP;
            S_GET_CAP:  state_next = S_RESP;
            S_FIND_LOOP: begin
                if (sts.idx_lt_cnt) begin
                    state_next = S_FIND_CHK;
                end else begin
                    state_next = S_RESP;
                end
            end
            S_FIND_CHK: begin
                if (sts.match) begin
                    state_next = S_RESP;
                end else begin
                    state_next = S_FIND_LOOP;
                end
            end
            S_RESP: begin
                if (sts.out_free) begin
                    state_next = S_IDLE;
                end
            end
            default:    state_next = S_IDLE;
        endcase
    end

    // Datapath commands
    always_comb begin
        cmd = '0;
        cmd.idx_op = IDX_HOLD;
        cmd.cnt_op = CNT_HOLD;
        cmd.rd_sel = RA_IDX;
        cmd.wr_sel = WA_POS;
        case (state_reg)
            S_IDLE: begin
                cmd.take = s_valid;
            end
            S_DECODE: begin
                case (sts.op)
                    OP_INSERT: begin
                        if (!sts.pos_le_cnt) begin
                            cmd.status_set  = 1'b1;
                            cmd.status_code = ST_BAD;
                        end else if (sts.full) begin
                            cmd.status_set  = 1'b1;
                            cmd.status_code = ST_FULL;
                        end else begin
                            cmd.idx_op = IDX_COUNT;
                        end
                    end
                    OP_REMOVE: begin
                        if (!sts.pos_lt_cnt) begin
                            cmd.status_set  = 1'b1;
                            cmd.status_code = ST_BAD;
                        end else begin
                            cmd.idx_op = IDX_POS1;
                        end
                    end
                    OP_REPLACE: begin
                        if (!sts.pos_lt_cnt) begin
                            cmd.status_set  = 1'b1;
                            cmd.status_code = ST_BAD;
                        end else begin
                            cmd.wr_en  = 1'b1;
                            cmd.wr_sel = WA_POS;
                        end
                    end
                    OP_GET: begin
                        if (!sts.pos_lt_cnt) begin
                            cmd.status_set  = 1'b1;
                            cmd.status_code = ST_BAD;
                        end else begin
                            cmd.rd_en  = 1'b1;
                            cmd.rd_sel = RA_POS;
                        end
                    end
                    OP_FIND: begin
                        cmd.idx_op = IDX_ZERO;
                    end
                    OP_CLEAR: begin
                        cmd.cnt_op = CNT_CLR;
                    end
                    default: begin
                        cmd.status_set  = 1'b1;
                        cmd.status_code = ST_BAD;
                    end
                endcase
            end
            S_INS_LOOP: begin
                // Fetch the entry below the hole, or drop the value in place
                if (sts.idx_gt_pos) begin
                    cmd.rd_en  = 1'b1;
                    cmd.rd_sel = RA_IDX_M1;
                end else begin
                    cmd.wr_en  = 1'b1;
                    cmd.wr_sel = WA_POS;
                    cmd.cnt_op = CNT_INC;
                end
            end
            S_INS_WR: begin
                cmd.wr_en  = 1'b1;
                cmd.wr_sel = WA_IDX;
                cmd.idx_op = IDX_DEC;
            end
            S_REM_LOOP: begin
                if (sts.idx_lt_cnt) begin
                    cmd.rd_en  = 1'b1;
                    cmd.rd_sel = RA_IDX;
                end else begin
                    cmd.cnt_op = CNT_DEC;
                end
            end
            S_REM_WR: begin
                cmd.wr_en  = 1'b1;
                cmd.wr_sel = WA_IDX_M1;
                cmd.idx_op = IDX_INC;
            end
            S_GET_CAP: begin
                cmd.read_cap = 1'b1;
            end
            S_FIND_LOOP: begin
                if (sts.idx_lt_cnt) begin
                    cmd.rd_en  = 1'b1;
                    cmd.rd_sel = RA_IDX;
                end
            end
            S_FIND_CHK: begin
                if (sts.match) begin
                    cmd.found_set = 1'b1;
                end else begin
                    cmd.idx_op = IDX_INC;
                end
            end
            S_RESP: begin
                cmd.out_load = sts.out_free;
            end
            default: begin
                cmd.take = 1'b0;
            end
        endcase
    end

    assign s_ready = (state_reg == S_IDLE);

endmodule

`default_nettype wire

/* hdl/pal_dp.sv */
// Datapath: entry store, count, scan index, result and output registers.
`default_nettype none

module pal_dp
    import pal_pkg::*;
(
    input  wire logic     aclk,
    input  wire logic     aresetn,
    input  wire pal_in_t  s_data,
    output logic          m_valid,
    input  wire logic     m_ready,
    output pal_out_t      m_data,
    input  wire pal_cmd_t cmd,
    output pal_sts_t      sts
);

    // Latched item
    logic [OP_W-1:0]     op_reg;
    logic [POS_W-1:0]    pos_reg;
    logic [DATA_W-1:0]   value_reg;

    // Control and working registers
    logic [CNT_W-1:0]    count_reg,  count_next;
    logic [CNT_W-1:0]    idx_reg,    idx_next;
    logic                m_valid_reg;
    logic [STATUS_W-1:0] status_reg, status_next;
    logic [DATA_W-1:0]   rdv_reg,    rdv_next;
    logic                found_reg,  found_next;
    pal_out_t            out_reg;

    // Address and compare helpers
    logic [CMP_W-1:0]    pos_ext;
    logic [CMP_W-1:0]    cnt_ext;
    logic [CMP_W-1:0]    idx_ext;
    logic [CMP_W-1:0]    pos_p1;
    logic [CNT_W-1:0]    idx_m1;
    logic [ADDR_W-1:0]   rd_addr;
    logic [ADDR_W-1:0]   wr_addr;
    logic [DATA_W-1:0]   wr_data;
    logic [DATA_W-1:0]   rd_data;

    assign pos_ext = CMP_W'(pos_reg);
    assign cnt_ext = CMP_W'(count_reg);
    assign idx_ext = CMP_W'(idx_reg);
    assign pos_p1  = pos_ext + 1'b1;
    assign idx_m1  = idx_reg - 1'b1;

    // Select memory addresses
    always_comb begin
        case (cmd.rd_sel)
            RA_IDX_M1: rd_addr = idx_m1[ADDR_W-1:0];
            RA_IDX:    rd_addr = idx_reg[ADDR_W-1:0];
            RA_POS:    rd_addr = pos_ext[ADDR_W-1:0];
            default:   rd_addr = idx_reg[ADDR_W-1:0];
        endcase
    end

    always_comb begin
        case (cmd.wr_sel)
            WA_IDX: begin
                wr_addr = idx_reg[ADDR_W-1:0];
                wr_data = rd_data;
            end
            WA_IDX_M1: begin
                wr_addr = idx_m1[ADDR_W-1:0];
                wr_data = rd_data;
            end
            WA_POS: begin
                wr_addr = pos_ext[ADDR_W-1:0];
                wr_data = value_reg;
            end
            default: begin
                wr_addr = pos_ext[ADDR_W-1:0];
                wr_data = value_reg;
            end
        endcase
    end

    pal_ram #(
        .WIDTH (DATA_W),
        .DEPTH (CAPACITY)
    ) u_ram (
        .aclk    (aclk),
        .wr_en   (cmd.wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_en   (cmd.rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    // Advance the scan index
    always_comb begin
        case (cmd.idx_op)
            IDX_HOLD:  idx_next = idx_reg;
            IDX_COUNT: idx_next = count_reg;
            IDX_POS1:  idx_next = pos_p1[CNT_W-1:0];
            IDX_ZERO:  idx_next = '0;
            IDX_INC:   idx_next = idx_reg + 1'b1;
            IDX_DEC:   idx_next = idx_m1;
            default:   idx_next = idx_reg;
        endcase
    end

    // Update the entry count
    always_comb begin
        case (cmd.cnt_op)
            CNT_HOLD: count_next = count_reg;
            CNT_INC:  count_next = count_reg + 1'b1;
            CNT_DEC:  count_next = count_reg - 1'b1;
            CNT_CLR:  count_next = '0;
            default:  count_next = count_reg;
        endcase
    end

    // Build the result fields
    always_comb begin
        status_next = status_reg;
        rdv_next    = rdv_reg;
        found_next  = found_reg;
        if (cmd.take) begin
            status_next = ST_OK;
            rdv_next    = '0;
            found_next  = 1'b0;
        end
        if (cmd.status_set) begin
            status_next = cmd.status_code;
        end
        if (cmd.read_cap) begin
            rdv_next = rd_data;
        end
        if (cmd.found_set) begin
            found_next = 1'b1;
        end
    end

    // Control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg   <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            count_reg <= count_next;
            if (cmd.out_load) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    // Payload registers
    always_ff @(posedge aclk) begin
        idx_reg    <= idx_next;
        status_reg <= status_next;
        rdv_reg    <= rdv_next;
        found_reg  <= found_next;
        if (cmd.take) begin
            op_reg    <= s_data.op;
            pos_reg   <= s_data.pos;
            value_reg <= s_data.value;
        end
        if (cmd.out_load) begin
            out_reg.status     <= status_reg;
            out_reg.read_value <= rdv_reg;
            out_reg.found      <= found_reg;
            out_reg.count      <= cnt_ext[COUNT_W-1:0];
        end
    end

    // Status to the controller
    always_comb begin
        sts.op         = op_reg;
        sts.pos_le_cnt = (pos_ext <= cnt_ext);
        sts.pos_lt_cnt = (pos_ext < cnt_ext);
        sts.full       = (cnt_ext >= CMP_W'(CAPACITY));
        sts.idx_gt_pos = (idx_ext > pos_ext);
        sts.idx_lt_cnt = (idx_reg < count_reg);
        sts.match      = (rd_data == value_reg);
        sts.out_free   = !m_valid_reg || m_ready;
    end

    assign m_valid = m_valid_reg;
    assign m_data  = out_reg;

    // Count stays within the store
    a_count_range: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= CAPACITY)
        else $error("entry count beyond capacity");

    // Grow only when there is room
    a_inc_room: assert property (@(posedge aclk) disable iff (!aresetn)
        (cmd.cnt_op == CNT_INC) |-> (count_reg < CAPACITY))
        else $error("insert into a full store");

    // Never overwrite a pending result
    a_no_overwrite: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.out_load |-> (!m_valid_reg || m_ready))
        else $error("result register overwritten");

    // Scans read only live entries
    a_live_read: assert property (@(posedge aclk) disable iff (!aresetn)
        (cmd.rd_en && cmd.rd_sel == RA_IDX) |-> (idx_reg < count_reg))
        else $error("read beyond the list");

endmodule

`default_nettype wire
